[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[hw/rtl/cse_pkg.sv]
// Types and constants of the cubic spline evaluator.
`default_nettype none

package cse_pkg;

    localparam int MAX_KNOTS_DEF = 256;
    localparam int DATA_W        = 32;
    localparam int KIU_W         = 9;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [KIU_W-1:0] KIU_RESET = 9'd2;

    // register index, taken from paddr[2]
    localparam logic REG_KNOTS_IN_USE = 1'b0;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Horner steps: coefficient added after each multiply
    localparam logic [1:0] STEP_QUAD = 2'd0;
    localparam logic [1:0] STEP_LIN  = 2'd1;
    localparam logic [1:0] STEP_ORD  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_UP,
        ST_DOWN,
        ST_HLOAD,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } cse_state_t;

endpackage

`default_nettype wire

[hw/rtl/cse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/cubic_spline_evaluator.sv]
// Cubic spline evaluator: knot tables, interval search and shared Horner multiplier.
//
//   port group   dir  handshake          word
//   s_*          in   s_valid/s_ready    load of one knot, or one query point
//   m_*          out  m_valid/m_ready    spline value and range flags
//   p*           in   APB, pready = 1    knots_in_use at byte address 0
//
// A knot load leaves the block ready for the next word. A query reads the abscissas
// of its search one per cycle, at least one (an upward search also reads the knot
// where it stops), then uses a shared 32x33 multiplier three times; no new word is
// accepted until its result has moved into the output register.
// Reset is synchronous and active low; the knot tables are not cleared.
// The result sits in an output register, so a query may be accepted while the
// previous result is still waiting; a finished query waits in ST_OUT while that register is full and m_ready is low.
`default_nettype none

module cubic_spline_evaluator #(
    parameter int MAX_KNOTS = cse_pkg::MAX_KNOTS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_kind,
    input  wire logic [7:0]                 s_knot_index,
    input  wire logic signed [31:0]         s_knot_abscissa_in,
    input  wire logic signed [31:0]         s_knot_ordinate_in,
    input  wire logic signed [31:0]         s_linear_coef_in,
    input  wire logic signed [31:0]         s_quadratic_coef_in,
    input  wire logic signed [31:0]         s_cubic_coef_in,
    input  wire logic signed [31:0]         s_query_point,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [31:0]              m_spline_value,
    output logic                            m_below_range,
    output logic                            m_above_range,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cse_pkg::APB_AW-1:0] paddr,
    input  wire logic [cse_pkg::APB_DW-1:0] pwdata,
    output logic      [cse_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);

`include "assert_macros.svh"

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int NW = $clog2(MAX_KNOTS + 1);
    localparam int CW = (NW > cse_pkg::KIU_W) ? NW : cse_pkg::KIU_W;
    localparam int DW = cse_pkg::DATA_W;

    cse_pkg::cse_state_t state_reg, state_next;

    logic [cse_pkg::KIU_W-1:0] kiu_reg;
    logic [AW-1:0]             i_reg, i_next;
    logic [AW-1:0]             last_int_reg, last_int_next;
    logic [AW-1:0]             last_idx_reg, last_idx_next;
    logic signed [DW-1:0]      u_reg, u_next;
    logic signed [DW:0]        d_reg, d_next;
    logic signed [DW-1:0]      acc_reg, acc_next;
    logic signed [2*DW:0]      prod_reg, prod_next;
    logic [1:0]                step_reg, step_next;
    logic                      below_reg, below_next;
    logic                      above_reg, above_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [DW-1:0]      m_value_reg, m_value_next;
    logic                      m_below_reg, m_below_next;
    logic                      m_above_reg, m_above_next;

    logic                      s_fire, q_fire, ld_we, cfg_we, look_up;
    logic [AW-1:0]             rd_addr, ld_addr;
    logic [DW-1:0]             x_rdata;
    logic [4*DW-1:0]           coef_rdata;
    logic signed [DW-1:0]      x_cur, coef_sel;
    logic signed [DW:0]        d_cur;
    logic [CW-1:0]             kiu_ext, n_clamp;
    logic [AW-1:0]             nm1, start_idx;

    assign s_fire  = s_valid && s_ready;
    assign q_fire  = s_fire && (s_kind == cse_pkg::KIND_QUERY);
    assign ld_we   = s_fire && (s_kind == cse_pkg::KIND_LOAD)
                     && (32'(s_knot_index) < 32'(MAX_KNOTS));
    assign ld_addr = AW'(s_knot_index);

    // APB register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == cse_pkg::REG_KNOTS_IN_USE);
    assign prdata = (paddr[2] == cse_pkg::REG_KNOTS_IN_USE)
                    ? cse_pkg::APB_DW'(kiu_reg) : '0;

    cse_ram #(.WIDTH(DW), .DEPTH(MAX_KNOTS)) u_x_ram (
        .clk   (aclk),
        .we    (ld_we),
        .waddr (ld_addr),
        .wdata (s_knot_abscissa_in),
        .raddr (rd_addr),
        .rdata (x_rdata)
    );

    cse_ram #(.WIDTH(4*DW), .DEPTH(MAX_KNOTS)) u_coef_ram (
        .clk   (aclk),
        .we    (ld_we),
        .waddr (ld_addr),
        .wdata ({s_cubic_coef_in, s_quadratic_coef_in, s_linear_coef_in,
                 s_knot_ordinate_in}),
        .raddr (rd_addr),
        .rdata (coef_rdata)
    );

    // knot count clamped to 2..MAX_KNOTS, search start clamped to n-2
    always_comb begin
        kiu_ext = CW'(kiu_reg);
        if (kiu_ext < CW'(2)) begin
            n_clamp = CW'(2);
        end else if (kiu_ext > CW'(MAX_KNOTS)) begin
            n_clamp = CW'(MAX_KNOTS);
        end else begin
            n_clamp = kiu_ext;
        end
        nm1 = AW'(n_clamp - CW'(1));
        start_idx = (last_int_reg > AW'(nm1 - AW'(1))) ? AW'(nm1 - AW'(1)) : last_int_reg;
    end

    assign x_cur = x_rdata;
    assign d_cur = {u_reg[DW-1], u_reg} - {x_cur[DW-1], x_cur};

    always_comb begin
        case (step_reg)
            cse_pkg::STEP_QUAD: coef_sel = coef_rdata[3*DW-1:2*DW];
            cse_pkg::STEP_LIN:  coef_sel = coef_rdata[2*DW-1:DW];
            cse_pkg::STEP_ORD:  coef_sel = coef_rdata[DW-1:0];
            default:            coef_sel = coef_rdata[DW-1:0];
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        last_int_next = last_int_reg;
        last_idx_next = last_idx_reg;
        u_next        = u_reg;
        d_next        = d_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        step_next     = step_reg;
        below_next    = below_reg;
        above_next    = above_reg;
        look_up       = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_below_next  = m_below_reg;
        m_above_next  = m_above_reg;

        case (state_reg)
            cse_pkg::ST_IDLE: begin
                if (q_fire) begin
                    u_next        = s_query_point;
                    last_idx_next = nm1;
                    i_next        = start_idx;
                    below_next    = 1'b0;
                    above_next    = 1'b0;
                    state_next    = cse_pkg::ST_FIRST;
                end
            end
            cse_pkg::ST_FIRST: begin
                d_next = d_cur;
                if (!d_cur[DW] && (d_cur != '0)) begin
                    look_up    = 1'b1;
                    state_next = cse_pkg::ST_UP;
                end else if (!d_cur[DW]) begin
                    state_next = cse_pkg::ST_HLOAD;
                end else if (i_reg == '0) begin
                    below_next = 1'b1;
                    state_next = cse_pkg::ST_HLOAD;
                end else begin
                    i_next     = i_reg - AW'(1);
                    state_next = cse_pkg::ST_DOWN;
                end
            end
            cse_pkg::ST_UP: begin
                // x_cur holds x[i+1]
                if (d_cur[DW]) begin
                    state_next = cse_pkg::ST_HLOAD;
                end else if (AW'(i_reg + AW'(1)) == last_idx_reg) begin
                    above_next = (d_cur != '0);
                    state_next = cse_pkg::ST_HLOAD;
                end else begin
                    i_next  = i_reg + AW'(1);
                    d_next  = d_cur;
                    look_up = 1'b1;
                end
            end
            cse_pkg::ST_DOWN: begin
                d_next = d_cur;
                if (!d_cur[DW]) begin
                    state_next = cse_pkg::ST_HLOAD;
                end else if (i_reg == '0) begin
                    below_next = 1'b1;
                    state_next = cse_pkg::ST_HLOAD;
                end else begin
                    i_next = i_reg - AW'(1);
                end
            end
            cse_pkg::ST_HLOAD: begin
                last_int_next = i_reg;
                acc_next      = coef_rdata[4*DW-1:3*DW];
                step_next     = cse_pkg::STEP_QUAD;
                state_next    = cse_pkg::ST_MUL;
            end
            cse_pkg::ST_MUL: begin
                prod_next  = acc_reg * d_reg;
                state_next = cse_pkg::ST_ADD;
            end
            cse_pkg::ST_ADD: begin
                // arithmetic shift by 16, then wrap to 32 bits
                acc_next  = prod_reg[DW+15:16] + coef_sel;
                step_next = step_reg + 2'd1;
                state_next = (step_reg == cse_pkg::STEP_ORD) ? cse_pkg::ST_OUT
                                                             : cse_pkg::ST_MUL;
            end
            cse_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = acc_reg;
                    m_below_next = below_reg;
                    m_above_next = above_reg;
                    state_next   = cse_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cse_pkg::ST_IDLE;
            end
        endcase

        rd_addr = look_up ? AW'(i_next + AW'(1)) : i_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cse_pkg::ST_IDLE;
            kiu_reg      <= cse_pkg::KIU_RESET;
            last_int_reg <= '0;
            last_idx_reg <= AW'(1);
            i_reg        <= '0;
            step_reg     <= cse_pkg::STEP_QUAD;
            below_reg    <= 1'b0;
            above_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_int_reg <= last_int_next;
            last_idx_reg <= last_idx_next;
            i_reg        <= i_next;
            step_reg     <= step_next;
            below_reg    <= below_next;
            above_reg    <= above_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                kiu_reg <= pwdata[cse_pkg::KIU_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        u_reg       <= u_next;
        d_reg       <= d_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        m_value_reg <= m_value_next;
        m_below_reg <= m_below_next;
        m_above_reg <= m_above_next;
    end

    assign s_ready        = (state_reg == cse_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_spline_value = m_value_reg;
    assign m_below_range  = m_below_reg;
    assign m_above_range  = m_above_reg;

    `ASSERT_PROP(a_interval_in_range, aclk, aresetn,
        (state_reg != cse_pkg::ST_IDLE) |-> (i_reg < last_idx_reg), "search interval beyond n-2")
    `ASSERT_PROP(a_below_at_first, aclk, aresetn,
        below_reg |-> (i_reg == '0), "below_range set away from interval 0")
    `ASSERT_NEVER(a_flags_exclusive, aclk, aresetn,
        below_reg && above_reg, "both range flags set")
    `ASSERT_PROP(a_busy_after_query, aclk, aresetn,
        q_fire |=> !s_ready, "ready right after a query")
    `ASSERT_PROP(a_out_holds, aclk, aresetn,
        ((state_reg == cse_pkg::ST_OUT) && m_valid_reg && !m_ready) |=>
        (state_reg == cse_pkg::ST_OUT), "result dropped while output busy")

endmodule

`default_nettype wire

[bench/cubic_spline_evaluator_test.sv]
// Self-checking testbench of the cubic spline evaluator: knot loads, queries, knot-count settings.
module cubic_spline_evaluator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KNOT_DEPTH    = cse_pkg::MAX_KNOTS_DEF;
    localparam int WORD_TARGET   = 1050;
    localparam int CALM_WORDS    = 150;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic               kind;
        logic [7:0]         index;
        logic signed [31:0] abscissa, ordinate, linear, quadratic, cubic, point;
    } spline_word_t;

    typedef struct {
        logic signed [31:0] value;
        logic               below;
        logic               above;
    } spline_result_t;

    class spline_tracker;
        logic signed [31:0] abscissa  [KNOT_DEPTH];
        logic signed [31:0] ordinate  [KNOT_DEPTH];
        logic signed [31:0] linear    [KNOT_DEPTH];
        logic signed [31:0] quadratic [KNOT_DEPTH];
        logic signed [31:0] cubic     [KNOT_DEPTH];
        int unsigned        last_interval;
        logic [cse_pkg::KIU_W-1:0] knot_count;
        spline_result_t     expected_q[$];
        int unsigned        mismatches, loads, queries, below_hits, above_hits;

        function new();
            last_interval = 0;
            knot_count    = cse_pkg::KIU_RESET;
            mismatches    = 0;
            loads         = 0;
            queries       = 0;
            below_hits    = 0;
            above_hits    = 0;
        endfunction

        function void set_knot_count(logic [cse_pkg::KIU_W-1:0] v);
            knot_count = v;
        endfunction

        function int unsigned active_knots();
            int unsigned n;
            n = 32'(knot_count);
            if (n < 2) n = 2;
            if (n > KNOT_DEPTH) n = KNOT_DEPTH;
            return n;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%0t: %s", $time, msg);
        endfunction

        // acc*d, floor shift by 16, add coefficient, wrap to 32 bits
        function logic signed [31:0] horner_mac(logic signed [31:0] acc, longint d,
                                                logic signed [31:0] coef);
            longint p;
            p = longint'(acc) * d;
            p = (p >>> 16) + longint'(coef);
            return p[31:0];
        endfunction

        function spline_result_t eval_spline(logic signed [31:0] point);
            spline_result_t     r;
            int unsigned        n, i;
            longint             u, d, dd;
            logic signed [31:0] acc;
            n = active_knots();
            i = last_interval;
            if (i > n - 2) i = n - 2;
            u = longint'(point);
            d = u - longint'(abscissa[i]);
            r.below = 1'b0;
            r.above = 1'b0;
            if (d > 0) begin
                dd = 0;
                while (i < n - 1) begin
                    dd = u - longint'(abscissa[i + 1]);
                    if (dd < 0) break;
                    i++;
                end
                if (i == n - 1) begin
                    r.above = (dd > 0);
                    i = n - 2;
                end
                d = u - longint'(abscissa[i]);
            end else begin
                while (d < 0) begin
                    if (i == 0) begin
                        r.below = 1'b1;
                        break;
                    end
                    i--;
                    d = u - longint'(abscissa[i]);
                end
            end
            last_interval = i;
            acc     = cubic[i];
            acc     = horner_mac(acc, d, quadratic[i]);
            acc     = horner_mac(acc, d, linear[i]);
            r.value = horner_mac(acc, d, ordinate[i]);
            return r;
        endfunction

        function void note_input(spline_word_t w);
            spline_result_t r;
            if (w.kind == cse_pkg::KIND_LOAD) begin
                // 8-bit index always lands inside the store
                abscissa[w.index]  = w.abscissa;
                ordinate[w.index]  = w.ordinate;
                linear[w.index]    = w.linear;
                quadratic[w.index] = w.quadratic;
                cubic[w.index]     = w.cubic;
                loads++;
            end else begin
                r = eval_spline(w.point);
                expected_q.push_back(r);
                queries++;
                if (r.below) below_hits++;
                if (r.above) above_hits++;
            end
        endfunction

        function void check_result(logic signed [31:0] value, logic below, logic above);
            spline_result_t e;
            if (expected_q.size() == 0) begin
                flag($sformatf("result word with none expected: value=%h below=%b above=%b",
                               value, below, above));
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.value)
                flag($sformatf("spline_value: expected %h, got %h", e.value, value));
            if (below !== e.below)
                flag($sformatf("below_range: expected %b, got %b", e.below, below));
            if (above !== e.above)
                flag($sformatf("above_range: expected %b, got %b", e.above, above));
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_kind;
    logic [7:0]                s_knot_index;
    logic signed [31:0]        s_knot_abscissa_in;
    logic signed [31:0]        s_knot_ordinate_in;
    logic signed [31:0]        s_linear_coef_in;
    logic signed [31:0]        s_quadratic_coef_in;
    logic signed [31:0]        s_cubic_coef_in;
    logic signed [31:0]        s_query_point;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [31:0]        m_spline_value;
    logic                      m_below_range;
    logic                      m_above_range;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [cse_pkg::APB_AW-1:0] paddr;
    logic [cse_pkg::APB_DW-1:0] pwdata;
    logic [cse_pkg::APB_DW-1:0] prdata;
    logic                      pready;

    spline_tracker tracker;
    int unsigned   words_sent = 0;
    int unsigned   filled     = 0;   // knot entries 0..filled-1 hold data
    int unsigned   settings   = 0;
    bit            calm       = 1'b0;
    bit            gappy      = 1'b0;

    cubic_spline_evaluator u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_knot_index       (s_knot_index),
        .s_knot_abscissa_in (s_knot_abscissa_in),
        .s_knot_ordinate_in (s_knot_ordinate_in),
        .s_linear_coef_in   (s_linear_coef_in),
        .s_quadratic_coef_in(s_quadratic_coef_in),
        .s_cubic_coef_in    (s_cubic_coef_in),
        .s_query_point      (s_query_point),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_spline_value     (m_spline_value),
        .m_below_range      (m_below_range),
        .m_above_range      (m_above_range),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic spline_word_t knot_word(int unsigned k, logic signed [31:0] x, y, b, c, e);
        spline_word_t w;
        w.kind      = cse_pkg::KIND_LOAD;
        w.index     = k[7:0];
        w.abscissa  = x;
        w.ordinate  = y;
        w.linear    = b;
        w.quadratic = c;
        w.cubic     = e;
        w.point     = $urandom;
        return w;
    endfunction

    function automatic spline_word_t query_word(logic signed [31:0] u);
        spline_word_t w;
        w.kind      = cse_pkg::KIND_QUERY;
        w.index     = 8'($urandom);
        w.abscissa  = $urandom;
        w.ordinate  = $urandom;
        w.linear    = $urandom;
        w.quadratic = $urandom;
        w.cubic     = $urandom;
        w.point     = u;
        return w;
    endfunction

    function automatic logic signed [31:0] rand_coef();
        logic signed [31:0] r;
        r = $urandom;
        if ($urandom_range(0, 3) != 0) r = r >>> $urandom_range(4, 30);
        return r;
    endfunction

    // mostly inside the table, some at knots, beyond either end, or anywhere
    function automatic logic signed [31:0] pick_point(int unsigned n);
        longint      u, lo, hi;
        int unsigned k;
        k  = $urandom_range(0, n - 2);
        lo = longint'(tracker.abscissa[k]);
        hi = longint'(tracker.abscissa[k + 1]);
        case ($urandom_range(0, 9))
            0: u = longint'($signed($urandom));
            1: u = longint'(tracker.abscissa[0]) - longint'($urandom_range(1, 32'h0010_0000));
            2: u = longint'(tracker.abscissa[n - 1]) + longint'($urandom_range(1, 32'h0010_0000));
            3: u = lo;
            4: u = longint'(tracker.abscissa[n - 1]);
            default: u = (hi > lo) ? lo + (hi - lo) * longint'($urandom_range(0, 1023)) / 1024
                                   : lo;
        endcase
        if (u < -64'sd2147483648) u = -64'sd2147483648;
        if (u > 64'sd2147483647) u = 64'sd2147483647;
        return u[31:0];
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_word(spline_word_t w);
        if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_kind              <= w.kind;
        s_knot_index        <= w.index;
        s_knot_abscissa_in  <= w.abscissa;
        s_knot_ordinate_in  <= w.ordinate;
        s_linear_coef_in    <= w.linear;
        s_quadratic_coef_in <= w.quadratic;
        s_cubic_coef_in     <= w.cubic;
        s_query_point       <= w.point;
        do @(posedge aclk); while (!s_ready);
        tracker.note_input(w);
        words_sent++;
        if (words_sent >= WORD_TARGET - CALM_WORDS) calm = 1'b1;
    endtask

    // hold off until every result is back, then let a trailing load settle
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_knot_count(logic [cse_pkg::KIU_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {cse_pkg::REG_KNOTS_IN_USE, 2'b00};
        pwdata  <= cse_pkg::APB_DW'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_knot_count(v);
        settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[cse_pkg::KIU_W-1:0] !== v)
            tracker.flag($sformatf("knots_in_use readback: expected %0d, got %0d",
                                   v, prdata[cse_pkg::KIU_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ascending abscissas, spacing either wide or tight
    task automatic load_table(int unsigned n);
        longint base, x, lim;
        base = -64'sd2147483648 + longint'($urandom_range(0, 32'h7FFF_FFFF));
        lim  = 64'sd2147483647 / n;
        if ($urandom_range(0, 1) == 1 && lim > 32'h0004_0000)
            lim = longint'($urandom_range(1, 32'h0004_0000));
        x = base;
        for (int unsigned k = 0; k < n; k++) begin
            send_word(knot_word(k, x[31:0], rand_coef(), rand_coef(), rand_coef(), rand_coef()));
            x += longint'($urandom_range(0, lim[31:0]));
        end
        if (n > filled) filled = n;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_spline_value, m_below_range, m_above_range);
    end

    initial begin
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 48)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned phase, n_eff, reg_val;
        tracker             = new();
        aresetn             <= 1'b0;
        s_valid             <= 1'b0;
        s_kind              <= cse_pkg::KIND_LOAD;
        s_knot_index        <= '0;
        s_knot_abscissa_in  <= '0;
        s_knot_ordinate_in  <= '0;
        s_linear_coef_in    <= '0;
        s_quadratic_coef_in <= '0;
        s_cubic_coef_in     <= '0;
        s_query_point       <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: four-knot table with extreme coefficients
        gappy = 1'b1;
        write_knot_count(9'd4);
        send_word(knot_word(0, -32'sd196608, 32'sh7FFF_FFFF, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 32'sh8000_0000));
        send_word(knot_word(1, -32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 32'sd0));
        send_word(knot_word(2, 32'sd65536, -32'sd65536, -32'sd32768, 32'sd16384, -32'sd8192));
        send_word(knot_word(3, 32'sd196608, 32'sd1, -32'sd1, 32'sd1, -32'sd1));
        filled = 4;
        send_word(query_word(32'sd0));
        send_word(query_word(32'sd196608));          // on the last knot: not above
        send_word(query_word(32'sd200000));
        send_word(query_word(32'sh7FFF_FFFF));
        send_word(query_word(-32'sd196608));         // on the first knot, searched downward
        send_word(query_word(32'sh8000_0000));       // below the table
        send_word(query_word(-32'sd100000));
        send_word(query_word(32'sd100000));
        send_word(query_word(32'sd65536));
        // stretch the table to the full abscissa range
        send_word(knot_word(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh7FFF_FFFF));
        send_word(knot_word(3, 32'sh7FFF_FFFF, -32'sd1, 32'sd1, -32'sd1, 32'sd1));
        send_word(query_word(32'sh8000_0000));
        send_word(query_word(32'sh7FFF_FFFF));
        send_word(query_word(32'sd0));
        // knots out of order
        send_word(knot_word(2, -32'sd300000, 32'sd4096, -32'sd4096, 32'sd256, 32'sd16));
        send_word(query_word(32'sd1000));
        send_word(query_word(-32'sd200000));

        phase = 0;
        while (words_sent < WORD_TARGET) begin
            drain();
            gappy = ($urandom_range(0, 2) != 0);
            case (phase)
                0: reg_val = 256;
                1: reg_val = 511;
                2: reg_val = 5;     // lowered count leaves the last interval stale
                3: reg_val = 0;
                4: reg_val = 1;
                5: reg_val = 257;
                6: reg_val = 2;
                default: reg_val = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 64)
                                                                : $urandom_range(2, 16);
            endcase
            write_knot_count(reg_val[cse_pkg::KIU_W-1:0]);
            n_eff = tracker.active_knots();
            if (n_eff > filled || (phase > 5 && $urandom_range(0, 2) != 0))
                load_table(n_eff);
            repeat ($urandom_range(8, 48)) begin
                if ($urandom_range(0, 11) == 0)
                    send_word(knot_word($urandom_range(0, 255), $urandom, rand_coef(),
                                        rand_coef(), rand_coef(), rand_coef()));
                else
                    send_word(query_word(pick_point(n_eff)));
            end
            phase++;
        end
        drain();

        $display("covered %0d knot loads and %0d queries over %0d knot-count settings",
                 tracker.loads, tracker.queries, settings);
        $display("%0d queries fell below the first knot, %0d beyond the last",
                 tracker.below_hits, tracker.above_hits);
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cse_pkg.sv
hw/rtl/cse_ram.sv
hw/rtl/cubic_spline_evaluator.sv
bench/cubic_spline_evaluator_test.sv
